@@ hdl/ssr_pkg.sv @@
// Shared constants and types for the servo slew ramp block.
`default_nettype none
package ssr_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int HALF_LEVEL  = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ANGLE_W = 8;
  localparam int SPEED_W = 10;
  localparam int MODE_W  = 2;
  localparam int OP_W    = 2;

  // interval divider: constant dividend over a speed-sized divisor
  localparam int DIV_W  = SPEED_W;
  localparam int STEP_W = $clog2(DIV_W);
  localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(1000);

  localparam logic [ANGLE_W-1:0] MAX_ANGLE   = ANGLE_W'(180);
  localparam logic [SPEED_W-1:0] ELAPSED_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_UNINIT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADJUST = 2'd2;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [ANGLE_W-1:0] angle;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    logic     pop;
    q_entry_t entry;
  } q_cmd_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] den;
  } div_cmd_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_res_t;

endpackage
`default_nettype wire

@@ hdl/ssr_div.sv @@
// Bit-serial restoring divider: constant dividend over a 10-bit divisor.
`default_nettype none
module ssr_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ssr_pkg::div_cmd_t cmd,
  output ssr_pkg::div_res_t      res
);
  import ssr_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvd;
  logic [DIV_W-1:0]  den;
  logic [DIV_W-1:0]  quot;
  logic [DIV_W:0]    trial;
  logic              qbit;

  assign trial = {rem, dvd[DIV_W-1]};
  assign qbit  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem  <= '0;
      dvd  <= DIVIDEND;
      den  <= cmd.den;
      quot <= '0;
    end else if (busy) begin
      rem  <= qbit ? DIV_W'(trial - {1'b0, den}) : trial[DIV_W-1:0];
      dvd  <= {dvd[DIV_W-2:0], 1'b0};
      quot <= {quot[DIV_W-2:0], qbit};
    end
  end

  assign res.done = done;
  assign res.quot = quot;

endmodule
`default_nettype wire

@@ hdl/ssr_queue.sv @@
// Ring FIFO of target entries with registered read data.
`default_nettype none
module ssr_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ssr_pkg::q_cmd_t        cmd,
  output ssr_pkg::q_entry_t           rd_entry,
  output logic [ssr_pkg::CNT_W-1:0]   count
);
  import ssr_pkg::*;

  q_entry_t         mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else if (cmd.push) begin
      wr_ptr <= wr_ptr + 1'b1;
      count  <= count + 1'b1;
    end else if (cmd.pop) begin
      rd_ptr <= rd_ptr + 1'b1;
      count  <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_ptr] <= cmd.entry;
    end
    if (cmd.pop) begin
      rd_entry <= mem[rd_ptr];
    end
  end

endmodule
`default_nettype wire

@@ hdl/servo_slew_ramp_with_target_queue.sv @@
// Servo slew ramp: target queue, mode sequencer and interval divider.
// Push, start and ticks with no step work go from idle straight to the emit state.
// A tick in adjusting mode first does the step work. A tick that enters adjusting pops,
// then runs the divider (10 steps, one quotient bit a cycle), then does the step work.
// One request in flight; a new one is taken while the last result waits.
// Synchronous reset: queue empty, mode uninitialized, angle 0, events disabled.
`default_nettype none
module servo_slew_ramp_with_target_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // target_angle[7:0], target_speed[17:8], zero pad
  input  wire logic [1:0]  s_tuser,  // operation[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // request_accepted[0], angle_written[1], servo_angle[9:2], mode[11:10],
  // queue_count[16:12], drain_request[17], drain_space[22:18], empty_event[23]
  output logic [23:0]      m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ssr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_WORK  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  localparam logic REG_EMPTY_EN = 1'b0;
  localparam logic REG_DRAIN_EN = 1'b1;

  logic [2:0] state;

  logic empty_en;
  logic drain_en;

  logic [MODE_W-1:0]  current_mode;
  logic [MODE_W-1:0]  pending_mode;
  logic [ANGLE_W-1:0] present_angle;
  logic [ANGLE_W-1:0] goal_angle;
  logic [DIV_W-1:0]   step_interval;
  logic [SPEED_W-1:0] elapsed_ticks;
  logic               first_step;
  logic               popped;

  logic res_accepted;
  logic res_written;
  logic res_drain;
  logic res_empty;

  q_cmd_t           q_cmd;
  q_entry_t         q_rd;
  logic [CNT_W-1:0] q_count;
  logic [CNT_W-1:0] count_after;
  div_cmd_t         div_cmd;
  div_res_t         div_res;

  logic               accept;
  logic [OP_W-1:0]    op;
  logic [ANGLE_W-1:0] in_angle;
  logic [SPEED_W-1:0] in_speed;
  logic               q_full;
  logic               enter_adjust;
  logic               cfg_wr;

  logic [SPEED_W-1:0] elapsed_inc;
  logic               step_due;

  ssr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .cmd      (q_cmd),
    .rd_entry (q_rd),
    .count    (q_count)
  );

  ssr_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .res (div_res)
  );

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign op       = s_tuser;
  assign in_angle = s_tdata[7:0];
  assign in_speed = s_tdata[17:8];
  assign q_full   = (q_count == CNT_W'(QUEUE_DEPTH));

  // mode change applied at the tick, entering adjusting
  assign enter_adjust = (op == OP_TICK) && (current_mode != pending_mode) &&
                        (pending_mode == MODE_ADJUST);

  assign q_cmd.push        = accept && (op == OP_PUSH) && !q_full;
  assign q_cmd.pop         = accept && enter_adjust && (q_count != '0);
  assign q_cmd.entry.angle = (in_angle > MAX_ANGLE) ? MAX_ANGLE : in_angle;
  assign q_cmd.entry.speed = in_speed;
  assign count_after       = q_count - 1'b1;

  // an empty queue on entry leaves the goal at the present angle
  assign div_cmd.start = (state == ST_FETCH);
  assign div_cmd.den   = (popped && (q_rd.speed != '0)) ? q_rd.speed : DIV_W'(1);

  assign elapsed_inc = (elapsed_ticks == ELAPSED_MAX) ? elapsed_ticks
                                                      : elapsed_ticks + 1'b1;
  assign step_due    = first_step || !(elapsed_inc < step_interval);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_EMPTY_EN: prdata = {31'b0, empty_en};
      REG_DRAIN_EN: prdata = {31'b0, drain_en};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_en <= 1'b0;
      drain_en <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_EMPTY_EN) begin
        empty_en <= pwdata[0];
      end else begin
        drain_en <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      current_mode  <= MODE_UNINIT;
      pending_mode  <= MODE_UNINIT;
      present_angle <= '0;
      goal_angle    <= '0;
      step_interval <= '0;
      elapsed_ticks <= '0;
      first_step    <= 1'b0;
      popped        <= 1'b0;
      res_accepted  <= 1'b0;
      res_written   <= 1'b0;
      res_drain     <= 1'b0;
      res_empty     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if ((state == ST_EMIT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_accepted <= ((op == OP_PUSH) && !q_full) ||
                            ((op == OP_START) && (current_mode == MODE_UNINIT));
            res_written  <= (op == OP_START) && (current_mode == MODE_UNINIT);
            // empty wins; a pop down to the half level raises drain
            res_empty    <= q_cmd.pop && (count_after == '0) && empty_en;
            res_drain    <= q_cmd.pop && (count_after == CNT_W'(HALF_LEVEL)) && drain_en;
            case (op)
              OP_PUSH: begin
                state <= ST_EMIT;
              end
              OP_START: begin
                if (current_mode == MODE_UNINIT) begin
                  pending_mode <= MODE_IDLE;
                end
                state <= ST_EMIT;
              end
              OP_TICK: begin
                // the current mode takes the pending mode held before this tick
                current_mode <= pending_mode;
                if (enter_adjust) begin
                  popped <= (q_count != '0);
                  state  <= ST_FETCH;
                end else if (pending_mode == MODE_ADJUST) begin
                  state <= ST_WORK;
                end else begin
                  if ((pending_mode == MODE_IDLE) && (q_count != '0)) begin
                    pending_mode <= MODE_ADJUST;
                  end
                  state <= ST_EMIT;
                end
              end
              default: begin
                state <= ST_EMIT;
              end
            endcase
          end
        end
        ST_FETCH: begin
          goal_angle <= popped ? q_rd.angle : present_angle;
          state      <= ST_DIV;
        end
        ST_DIV: begin
          if (div_res.done) begin
            step_interval <= div_res.quot;
            first_step    <= 1'b1;
            state         <= ST_WORK;
          end
        end
        ST_WORK: begin
          first_step <= 1'b0;
          if (step_due && (goal_angle != present_angle)) begin
            present_angle <= (goal_angle > present_angle) ? present_angle + 1'b1
                                                          : present_angle - 1'b1;
            elapsed_ticks <= '0;
            res_written   <= 1'b1;
          end else begin
            if (!first_step) begin
              elapsed_ticks <= elapsed_inc;
            end
            if (step_due && (pending_mode != MODE_IDLE)) begin
              pending_mode <= MODE_IDLE;
            end
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && (!m_tvalid || m_tready)) begin
      m_tdata <= {res_empty,
                  res_drain ? 5'(QUEUE_DEPTH - HALF_LEVEL) : 5'd0,
                  res_drain,
                  5'(q_count),
                  current_mode,
                  present_angle,
                  res_written,
                  res_accepted};
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_work_adjust: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WORK) |-> (current_mode == MODE_ADJUST))
    else $error("step work outside adjusting mode");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != ST_IDLE))
    else $error("request taken without leaving idle");

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking stream and register testbench for the servo slew ramp block.
module testbench;
  import ssr_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] REG_EMPTY_EN = 3'd0;
  localparam logic [2:0] REG_DRAIN_EN = 3'd4;
  localparam int RANDOM_PER_PHASE = 160;
  localparam int LONG_HOLD = 150;
  localparam int DIRECTED_ROWS = 13;

  // packed MSB first so that the output bus casts straight onto it
  typedef struct packed {
    logic         empty_event;
    logic [4:0]   drain_space;
    logic         drain_request;
    logic [4:0]   queue_count;
    logic [1:0]   mode;
    logic [7:0]   servo_angle;
    logic         angle_written;
    logic         request_accepted;
  } servo_result_t;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [ANGLE_W-1:0] angle;
    logic [SPEED_W-1:0] speed;
    int                 reps;
    bit                 typed;
    servo_result_t      want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // target_angle[7:0], target_speed[17:8], zero pad
  logic [1:0]  s_tuser;   // operation[1:0]
  logic        m_tvalid;
  logic        m_tready;
  // request_accepted[0], angle_written[1], servo_angle[9:2], mode[11:10],
  // queue_count[16:12], drain_request[17], drain_space[22:18], empty_event[23]
  logic [23:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  servo_slew_ramp_with_target_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // slew model state
  logic [ANGLE_W-1:0] q_angle [QUEUE_DEPTH];
  logic [SPEED_W-1:0] q_speed [QUEUE_DEPTH];
  logic [PTR_W-1:0]   rd_ptr = '0;
  logic [PTR_W-1:0]   wr_ptr = '0;
  int                 n_entries = 0;
  logic [MODE_W-1:0]  cur_mode = MODE_UNINIT;
  logic [MODE_W-1:0]  next_mode = MODE_UNINIT;
  int                 angle_now = 0;
  int                 angle_goal = 0;
  int                 interval = 0;
  int                 elapsed = 0;
  bit                 first_step = 1'b0;
  bit                 cfg_empty_en = 1'b0;
  bit                 cfg_drain_en = 1'b0;

  servo_result_t awaited_results [$];
  stim_row_t     directed_rows [DIRECTED_ROWS];

  int  error_count = 0;
  int  n_requests = 0;
  int  n_directed = 0;
  int  n_results = 0;
  int  n_drain = 0;
  int  n_empty = 0;
  int  n_full = 0;
  int  send_count = 0;
  bit  sender_quiet = 1'b0;
  int  hold_off_asked = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("servo_slew_ramp_with_target_queue test failed");
    $finish;
  end

  function automatic servo_result_t res(bit acc, bit wr, int angle, logic [1:0] mode,
                                        int count);
    servo_result_t r;
    r = '0;
    r.request_accepted = acc;
    r.angle_written = wr;
    r.servo_angle = angle[7:0];
    r.mode = mode;
    r.queue_count = count[4:0];
    return r;
  endfunction

  function automatic void ask_mode(logic [MODE_W-1:0] m);
    if (m != cur_mode && m != next_mode) next_mode = m;
  endfunction

  function automatic servo_result_t slew_predict(logic [OP_W-1:0] op,
                                                 logic [ANGLE_W-1:0] angle_in,
                                                 logic [SPEED_W-1:0] speed_in);
    servo_result_t r;
    int spd;
    bit go;
    bit moved;
    r = '0;
    go = 1'b1;
    moved = 1'b0;
    case (op)
      OP_PUSH: begin
        if (n_entries < QUEUE_DEPTH) begin
          q_angle[wr_ptr] = (angle_in > MAX_ANGLE) ? MAX_ANGLE : angle_in;
          q_speed[wr_ptr] = speed_in;
          wr_ptr = wr_ptr + 1'b1;
          n_entries++;
          r.request_accepted = 1'b1;
        end
      end
      OP_START: begin
        if (cur_mode == MODE_UNINIT) begin
          r.angle_written = 1'b1;
          ask_mode(MODE_IDLE);
          r.request_accepted = 1'b1;
        end
      end
      OP_TICK: begin
        if (cur_mode != next_mode) begin
          cur_mode = next_mode;
          if (cur_mode == MODE_ADJUST) begin
            spd = 1;
            if (n_entries == 0) begin
              angle_goal = angle_now;
            end else begin
              angle_goal = int'(q_angle[rd_ptr]);
              spd = int'(q_speed[rd_ptr]);
              rd_ptr = rd_ptr + 1'b1;
              n_entries--;
              // empty wins over drain
              if (n_entries == 0) begin
                r.empty_event = cfg_empty_en;
              end else if (n_entries == HALF_LEVEL && cfg_drain_en) begin
                r.drain_request = 1'b1;
                r.drain_space = 5'(QUEUE_DEPTH - n_entries);
              end
            end
            if (spd == 0) spd = 1;
            interval = 1000 / spd;
            first_step = 1'b1;
          end
        end
        if (cur_mode == MODE_ADJUST) begin
          if (first_step) begin
            first_step = 1'b0;
          end else begin
            if (elapsed < int'(ELAPSED_MAX)) elapsed++;
            go = (elapsed >= interval);
          end
          if (go) begin
            if (angle_goal > angle_now) begin
              angle_now++;
              moved = 1'b1;
            end else if (angle_goal < angle_now) begin
              angle_now--;
              moved = 1'b1;
            end else begin
              ask_mode(MODE_IDLE);
            end
          end
          if (moved) begin
            elapsed = 0;
            r.angle_written = 1'b1;
          end
        end else if (cur_mode == MODE_IDLE && n_entries != 0) begin
          ask_mode(MODE_ADJUST);
        end
      end
      default: ;
    endcase
    r.servo_angle = angle_now[7:0];
    r.mode = cur_mode;
    r.queue_count = n_entries[4:0];
    return r;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // next target chains from the last queued one so most ramps stay short
  task automatic pick_target(output logic [ANGLE_W-1:0] angle,
                             output logic [SPEED_W-1:0] speed);
    logic [PTR_W-1:0] tail_ptr;
    int base;
    int t;
    tail_ptr = wr_ptr - 1'b1;
    if (n_entries != 0) base = int'(q_angle[tail_ptr]);
    else if (cur_mode == MODE_ADJUST) base = angle_goal;
    else base = angle_now;
    if ($urandom_range(0, 19) == 0) begin
      angle = 8'($urandom_range(0, 255));
      speed = 10'($urandom_range(1001, 1023));
    end else begin
      t = base + int'($urandom_range(0, 24)) - 12;
      if (t < 0) t = 0;
      if (t > int'(MAX_ANGLE)) t = int'(MAX_ANGLE);
      angle = t[7:0];
      if ($urandom_range(0, 9) < 5) speed = 10'($urandom_range(1001, 1023));
      else speed = 10'($urandom_range(100, 1000));
    end
  endtask

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_result(logic [23:0] data);
    servo_result_t got;
    servo_result_t want;
    got = data;
    n_results++;
    if (awaited_results.size() == 0) begin
      $error("result %h with no request outstanding", data);
      error_count++;
    end else begin
      want = awaited_results.pop_front();
      compare_field("request_accepted", 8'(want.request_accepted),
                    8'(got.request_accepted));
      compare_field("angle_written", 8'(want.angle_written), 8'(got.angle_written));
      compare_field("servo_angle", want.servo_angle, got.servo_angle);
      compare_field("mode", 8'(want.mode), 8'(got.mode));
      compare_field("queue_count", 8'(want.queue_count), 8'(got.queue_count));
      compare_field("drain_request", 8'(want.drain_request), 8'(got.drain_request));
      compare_field("drain_space", 8'(want.drain_space), 8'(got.drain_space));
      compare_field("empty_event", 8'(want.empty_event), 8'(got.empty_event));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
  end

  // result sink: random back-pressure plus one long hold when asked
  initial begin
    int stall_left;
    int cycles;
    int holds_done;
    bit quiet;
    stall_left = 0;
    cycles = 0;
    holds_done = 0;
    quiet = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      cycles++;
      if (cycles % 200 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (holds_done != hold_off_asked) begin
        holds_done = hold_off_asked;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_gap(quiet);
      end
    end
  end

  task automatic send_request(logic [OP_W-1:0] op, logic [ANGLE_W-1:0] angle,
                              logic [SPEED_W-1:0] speed, bit typed, servo_result_t want);
    servo_result_t predicted;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {6'b0, speed, angle};
    do @(posedge clk); while (!s_tready);
    predicted = slew_predict(op, angle, speed);
    if (predicted.drain_request) n_drain++;
    if (predicted.empty_event) n_empty++;
    if (op == OP_PUSH && !predicted.request_accepted) n_full++;
    awaited_results.push_back(typed ? want : predicted);
    n_requests++;
  endtask

  task automatic idle_after();
    int gap;
    send_count++;
    if (send_count % 50 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
    gap = pick_gap(sender_quiet);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  task automatic random_tick();
    send_request(OP_TICK, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                 1'b0, '0);
    idle_after();
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr)
      REG_EMPTY_EN: cfg_empty_en = value[0];
      REG_DRAIN_EN: cfg_drain_en = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_check(logic [2:0] addr, bit value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, value}) begin
      $error("prdata at %0d: expected %0d, got %0d", addr, value, prdata);
      error_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_events(bit empty_en, bit drain_en);
    apb_write(REG_EMPTY_EN, {31'b0, empty_en});
    apb_write(REG_DRAIN_EN, {31'b0, drain_en});
    apb_check(REG_EMPTY_EN, empty_en);
    apb_check(REG_DRAIN_EN, drain_en);
  endtask

  // bursts of pushes and runs of ticks, with a little noise
  task automatic random_phase(int phase);
    int done;
    int k;
    int n;
    logic [ANGLE_W-1:0] angle;
    logic [SPEED_W-1:0] speed;
    bit held;
    bit paused;
    done = 0;
    held = 1'b0;
    paused = 1'b0;
    while (done < RANDOM_PER_PHASE) begin
      if (done >= RANDOM_PER_PHASE / 2 && phase == 1 && !held) begin
        held = 1'b1;
        hold_off_asked++;
      end
      if (done >= RANDOM_PER_PHASE / 2 && phase == 2 && !paused) begin
        paused = 1'b1;
        wait_results_drained();
      end
      k = $urandom_range(0, 99);
      if (k < 30) begin
        n = $urandom_range(1, 12);
        repeat (n) begin
          pick_target(angle, speed);
          send_request(OP_PUSH, angle, speed, 1'b0, '0);
          idle_after();
        end
        done += n;
      end else if (k < 92) begin
        n = $urandom_range(5, 60);
        repeat (n) random_tick();
        done += n;
      end else if (k < 96) begin
        send_request(OP_UNUSED, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                     1'b0, '0);
        idle_after();
      end else begin
        send_request(OP_START, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                     1'b0, '0);
        idle_after();
      end
    end
  endtask

  initial begin
    int i;
    int p;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    directed_rows = '{
      '{OP_UNUSED, 8'hFF, 10'h3FF, 1, 1'b1, res(1'b0, 1'b0, 0, MODE_UNINIT, 0)},
      '{OP_TICK, 8'h00, 10'h000, 1, 1'b1, res(1'b0, 1'b0, 0, MODE_UNINIT, 0)},
      '{OP_START, 8'h00, 10'h000, 1, 1'b1, res(1'b1, 1'b1, 0, MODE_UNINIT, 0)},
      // second start before any tick is taken again
      '{OP_START, 8'h5A, 10'h2A5, 1, 1'b1, res(1'b1, 1'b1, 0, MODE_UNINIT, 0)},
      // angle clamps to 180, fastest speed steps every tick
      '{OP_PUSH, 8'hFF, 10'h3FF, 1, 1'b1, res(1'b1, 1'b0, 0, MODE_UNINIT, 1)},
      '{OP_PUSH, 8'd180, 10'd1001, 14, 1'b0, '0},
      // zero speed is stored as given; it pops at the angle already reached
      '{OP_PUSH, 8'd180, 10'd0, 1, 1'b1, res(1'b1, 1'b0, 0, MODE_UNINIT, 16)},
      '{OP_PUSH, 8'd90, 10'd500, 1, 1'b1, res(1'b0, 1'b0, 0, MODE_UNINIT, 16)},
      '{OP_TICK, 8'h00, 10'h000, 1, 1'b1, res(1'b0, 1'b0, 0, MODE_IDLE, 16)},
      '{OP_START, 8'h00, 10'h000, 1, 1'b1, res(1'b0, 1'b0, 0, MODE_IDLE, 16)},
      '{OP_UNUSED, 8'h00, 10'h000, 1, 1'b1, res(1'b0, 1'b0, 0, MODE_IDLE, 16)},
      '{OP_TICK, 8'h00, 10'h000, 1, 1'b0, '0},
      '{OP_TICK, 8'h00, 10'h000, 4, 1'b0, '0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apb_check(REG_EMPTY_EN, 1'b0);
    apb_check(REG_DRAIN_EN, 1'b0);
    set_events(1'b1, 1'b1);

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      repeat (directed_rows[i].reps) begin
        send_request(directed_rows[i].op, directed_rows[i].angle, directed_rows[i].speed,
                     directed_rows[i].typed, directed_rows[i].want);
        idle_after();
      end
    end
    n_directed = n_requests;

    // run the full queue down, through the drain and empty events
    while (!(cur_mode == MODE_IDLE && next_mode == MODE_IDLE && n_entries == 0))
      random_tick();

    for (p = 0; p < 4; p++) begin
      wait_results_drained();
      case (p)
        0: set_events(1'b0, 1'b0);
        1: set_events(1'b1, 1'b1);
        2: set_events(1'b1, 1'b0);
        default: set_events(1'b0, 1'b1);
      endcase
      random_phase(p);
    end

    wait_results_drained();
    repeat (20) @(posedge clk);
    $display("%0d requests (%0d directed) gave %0d results; four event settings",
             n_requests, n_directed, n_results);
    $display("%0d drain requests, %0d empty events, %0d pushes refused on a full queue",
             n_drain, n_empty, n_full);
    if (error_count == 0) begin
      $display("servo_slew_ramp_with_target_queue test passed");
    end else begin
      $display("servo_slew_ramp_with_target_queue test failed");
    end
    $finish;
  end

endmodule

@@ servo_slew_ramp_with_target_queue.f @@
hdl/ssr_pkg.sv
hdl/ssr_div.sv
hdl/ssr_queue.sv
hdl/servo_slew_ramp_with_target_queue.sv
test/testbench.sv
